@@ sv/mfb32_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb32_pkg
// Shared widths, register indexes and codes for the minifloat converter.
// ----------------------------------------------------------------------------
package mfb32_pkg;
  localparam int PatternWidth  = 16;
  localparam int SingleWidth   = 32;
  localparam int FracCfgWidth  = 4;
  localparam int ExpCfgWidth   = 3;
  localparam int CfgDataWidth  = 4;
  localparam int CfgIndexWidth = 1;

  localparam logic [CfgIndexWidth-1:0] RegFractionWidth = 1'd0;
  localparam logic [CfgIndexWidth-1:0] RegExponentWidth = 1'd1;

  localparam logic [FracCfgWidth-1:0] FracMin   = 4'd2;
  localparam logic [FracCfgWidth-1:0] FracMax   = 4'd10;
  localparam logic [FracCfgWidth-1:0] FracReset = 4'd4;
  localparam logic [ExpCfgWidth-1:0]  ExpMin    = 3'd3;
  localparam logic [ExpCfgWidth-1:0]  ExpMax    = 3'd5;
  localparam logic [ExpCfgWidth-1:0]  ExpReset  = 3'd3;

  typedef logic [1:0] value_class_t;
  localparam value_class_t ClassZeroSub = 2'd0;
  localparam value_class_t ClassNormal  = 2'd1;
  localparam value_class_t ClassInf     = 2'd2;
  localparam value_class_t ClassNan     = 2'd3;

  localparam logic [SingleWidth-1:0] QuietNan = 32'h7FC0_0000;
  localparam logic [SingleWidth-1:0] InfBits  = 32'h7F80_0000;
endpackage

@@ sv/mfb32_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb32_in_if / mfb32_out_if / mfb32_cfg_if
// Valid/ready channels of the minifloat converter.
// ----------------------------------------------------------------------------
interface mfb32_in_if import mfb32_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PatternWidth-1:0] pattern;
  modport source (output valid, output pattern, input ready);
  modport sink (input valid, input pattern, output ready);
endinterface

interface mfb32_out_if import mfb32_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SingleWidth-1:0] single_bits;
  value_class_t           value_class;
  logic                   too_wide;
  modport source (output valid, output single_bits, output value_class, output too_wide,
                  input ready);
  modport sink (input valid, input single_bits, input value_class, input too_wide,
                output ready);
endinterface

interface mfb32_cfg_if import mfb32_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/minifloat_to_binary32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minifloat_to_binary32
// Converts a small IEEE-style float of configurable width to binary32.
// ----------------------------------------------------------------------------
// Usage: words enter on in (pattern) and leave on out (single_bits,
// value_class, too_wide), one result word for each input word. The cfg
// channel writes the fraction width (index 0) and exponent width (index 1);
// it is always ready and should be used only while the block is empty.
// A word passes through the input register, then the decode logic into the
// result register. One word is taken every cycle unless out stalls with both
// registers full; the rate is set by the single-pass decode between the two.
// A full result register drops in.ready only when out is stalled and the
// input register is also full, so the input register acts as a skid stage.
// Reset empties both registers and restores widths to 4 and 3.
// Out-of-range widths are clamped when used; the registers keep the bits (exponent: low three).
module minifloat_to_binary32 import mfb32_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  mfb32_in_if.sink       in,
  mfb32_out_if.source    out,
  mfb32_cfg_if.sink      cfg
);
  logic [FracCfgWidth-1:0] fraction_width;
  logic [ExpCfgWidth-1:0]  exponent_width;
  logic                    in_full;
  logic [PatternWidth-1:0] in_pattern;
  logic                    out_full;
  logic [SingleWidth-1:0]  single_bits;
  value_class_t            value_class;
  logic                    too_wide;

  logic                    advance;
  logic [3:0]              f;
  logic [2:0]              e;
  logic [4:0]              total;
  logic [PatternWidth-1:0] pat_sh;
  logic [9:0]              frac;
  logic [4:0]              expo;
  logic [4:0]              emax;
  logic [4:0]              bias;
  logic                    sign;
  logic [3:0]              p;
  logic [7:0]              e32;
  logic [22:0]             mant;
  logic [SingleWidth-1:0]  bits_next;
  value_class_t            class_next;
  logic                    wide_next;

  assign cfg.ready = 1'b1;
  assign advance   = in_full && (!out_full || out.ready);
  assign in.ready  = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_width <= FracReset;
      exponent_width <= ExpReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegFractionWidth: fraction_width <= cfg.data;
        RegExponentWidth: exponent_width <= cfg.data[ExpCfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in.valid && in.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in.valid && in.ready) begin
      in_pattern <= in.pattern;
    end
  end

  always_comb begin
    f = (fraction_width < FracMin) ? FracMin :
        (fraction_width > FracMax) ? FracMax : fraction_width;
    e = (exponent_width < ExpMin) ? ExpMin :
        (exponent_width > ExpMax) ? ExpMax : exponent_width;
    total     = 5'd1 + {2'd0, e} + {1'b0, f};
    wide_next = (in_pattern >> total) != '0;
    frac      = in_pattern[9:0] & ((10'd1 << f) - 10'd1);
    pat_sh    = in_pattern >> f;
    emax      = (5'd1 << e) - 5'd1;
    expo      = pat_sh[4:0] & emax;
    sign      = pat_sh[e];
    bias      = (5'd1 << (e - 3'd1)) - 5'd1;
    // Leading-one position of the subnormal fraction.
    p = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (frac[i]) p = 4'(i);
    end
    e32  = '0;
    mant = '0;
    if (expo == emax) begin
      if (frac == '0) begin
        bits_next  = {sign, 31'd0} | InfBits;
        class_next = ClassInf;
      end else begin
        bits_next  = QuietNan;
        class_next = ClassNan;
      end
    end else if (expo != '0) begin
      e32        = 8'(expo) + 8'd127 - 8'(bias);
      mant       = 23'(frac) << (5'd23 - 5'(f));
      bits_next  = {sign, e32, mant};
      class_next = ClassNormal;
    end else if (frac == '0) begin
      bits_next  = {sign, 31'd0};
      class_next = ClassZeroSub;
    end else begin
      e32        = 8'd128 + 8'(p) - 8'(bias) - 8'(f);
      mant       = 23'(frac ^ (10'd1 << p)) << (5'd23 - 5'(p));
      bits_next  = {sign, e32, mant};
      class_next = ClassZeroSub;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out.ready) begin
      out_full <= 1'b0;
    end
    if (advance) begin
      single_bits <= bits_next;
      value_class <= class_next;
      too_wide    <= wide_next;
    end
  end

  assign out.valid       = out_full;
  assign out.single_bits = single_bits;
  assign out.value_class = value_class;
  assign out.too_wide    = too_wide;

  a_nan_quiet: assert property (@(posedge clk) disable iff (rst)
    out_full && value_class == ClassNan |-> single_bits == QuietNan)
    else $error("NaN result is not the quiet pattern");
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    out_full && !out.ready |=> out_full)
    else $error("stalled result word was dropped");
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> in.ready)
    else $error("input not ready with an empty input register");
endmodule

@@ tb/sv/minifloat_to_binary32_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minifloat_to_binary32_tb
// Drives minifloat patterns under several width settings, predicts the
// binary32 word, class and width flag of each, and checks every result word.
// ----------------------------------------------------------------------------
module minifloat_to_binary32_tb;
  import mfb32_pkg::*;

  typedef struct packed {
    logic [SingleWidth-1:0] single_bits;
    value_class_t           value_class;
    logic                   too_wide;
  } conv_t;

  class conv_scoreboard;
    logic [FracCfgWidth-1:0] frac_reg;
    logic [ExpCfgWidth-1:0]  exp_reg;
    conv_t                   pending[$];
    int                      errors;

    function new();
      frac_reg = FracReset;
      exp_reg  = ExpReset;
      errors   = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
      if (idx == RegFractionWidth) frac_reg = d[FracCfgWidth-1:0];
      else if (idx == RegExponentWidth) exp_reg = d[ExpCfgWidth-1:0];
    endfunction

    function conv_t convert(logic [PatternWidth-1:0] pat);
      conv_t r;
      int f, e, fr, ex, sg, emax, bias, p, e32;
      logic [31:0] m;
      f = int'(frac_reg < FracMin ? FracMin : (frac_reg > FracMax ? FracMax : frac_reg));
      e = int'(exp_reg < ExpMin ? ExpMin : (exp_reg > ExpMax ? ExpMax : exp_reg));
      r.too_wide = (32'(pat) >> (1 + e + f)) != 0;
      fr = int'(pat) & ((1 << f) - 1);
      ex = (int'(pat) >> f) & ((1 << e) - 1);
      sg = (int'(pat) >> (e + f)) & 1;
      emax = (1 << e) - 1;
      bias = (1 << (e - 1)) - 1;
      if (ex == emax) begin
        if (fr == 0) begin
          r.single_bits = {sg[0], 31'h0} | InfBits;
          r.value_class = ClassInf;
        end else begin
          r.single_bits = QuietNan;
          r.value_class = ClassNan;
        end
      end else if (ex != 0) begin
        e32 = ex + 127 - bias;
        m = 32'(fr) << (23 - f);
        r.single_bits = {sg[0], e32[7:0], m[22:0]};
        r.value_class = ClassNormal;
      end else if (fr == 0) begin
        r.single_bits = {sg[0], 31'h0};
        r.value_class = ClassZeroSub;
      end else begin
        p = 0;
        while ((fr >> (p + 1)) != 0) p++;
        e32 = 127 + p + 1 - bias - f;
        m = 32'(fr - (1 << p)) << (23 - p);
        r.single_bits = {sg[0], e32[7:0], m[22:0]};
        r.value_class = ClassZeroSub;
      end
      return r;
    endfunction

    function void note_input(logic [PatternWidth-1:0] pat);
      pending.push_back(convert(pat));
    endfunction

    function void check_result(conv_t got);
      conv_t exp_r;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.single_bits !== exp_r.single_bits) begin
        $error("single_bits expected %h actual %h", exp_r.single_bits, got.single_bits);
        errors++;
      end
      if (got.value_class !== exp_r.value_class) begin
        $error("value_class expected %0d actual %0d", exp_r.value_class, got.value_class);
        errors++;
      end
      if (got.too_wide !== exp_r.too_wide) begin
        $error("too_wide expected %0d actual %0d", exp_r.too_wide, got.too_wide);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;

  mfb32_in_if  in_ch();
  mfb32_out_if out_ch();
  mfb32_cfg_if cfg_ch();

  conv_scoreboard sb = new();

  minifloat_to_binary32 uut (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stalls, result checked at each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.single_bits, out_ch.value_class, out_ch.too_wide});
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid stays high after the accepting edge so that words can follow
  // back to back; the next idle cycle or drain() lowers it.
  task automatic send_word(logic [PatternWidth-1:0] pat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pattern <= pat;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(pat);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random word: mostly in-format patterns, some with stray high bits.
  function automatic logic [PatternWidth-1:0] rand_pattern();
    int f, e, w;
    logic [PatternWidth-1:0] p;
    f = int'(sb.frac_reg < FracMin ? FracMin :
             (sb.frac_reg > FracMax ? FracMax : sb.frac_reg));
    e = int'(sb.exp_reg < ExpMin ? ExpMin : (sb.exp_reg > ExpMax ? ExpMax : sb.exp_reg));
    w = 1 + e + f;
    p = 16'($urandom());
    if ($urandom_range(3) != 0 && w < 16) p = p & 16'((1 << w) - 1);
    // Bias toward the exponent extremes where the special classes live.
    case ($urandom_range(3))
      0: p = p & ~16'(((1 << e) - 1) << f);
      1: p = p | 16'(((1 << e) - 1) << f);
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    logic [3:0] fset[8] = '{4'd4, 4'd2, 4'd10, 4'd0, 4'd15, 4'd7, 4'd10, 4'd3};
    logic [3:0] eset[8] = '{4'd3, 4'd5, 4'd3, 4'd0, 4'd7, 4'd4, 4'd5, 4'd2};
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.pattern = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegFractionWidth;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset widths (f=4, e=3).
    send_word(16'h0000); send_word(16'h0040); send_word(16'h0001);
    send_word(16'h000F); send_word(16'h0010); send_word(16'h005F);
    send_word(16'h0070); send_word(16'h00F0); send_word(16'h0071);
    send_word(16'h00FF); send_word(16'h0080); send_word(16'hFFFF);
    send_word(16'h0100); send_word(16'h8001);
    drain();
    write_cfg(RegFractionWidth, 4'd10);
    write_cfg(RegExponentWidth, 4'd5);
    send_word(16'h0001); send_word(16'h03FF); send_word(16'h7C00);
    send_word(16'hFC00); send_word(16'h7FFF); send_word(16'h0400);
    send_word(16'h7BFF); send_word(16'h8000);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 8 : 0;
      for (int s = 0; s < 8; s++) begin
        write_cfg(RegFractionWidth, fset[s]);
        write_cfg(RegExponentWidth, eset[(s + ph) % 8]);
        for (int i = 0; i < 55; i++) begin
          send_word(rand_pattern());
          if (i == 30 && s == 2) drain();
        end
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
